// File: rtl/stct_pkg.sv
// ----------------------------------------------------------------------------
// stct_pkg
// shared types and constants for the sparse triplet compress/transpose block
// ----------------------------------------------------------------------------
package stct_pkg;

    localparam int MAX_DIM     = 16;
    localparam int NZ_CAPACITY = 31;

    localparam int DIM_W   = 5;   // holds a dimension 1..MAX_DIM
    localparam int POS_W   = 4;   // holds a position 0..MAX_DIM-1
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 5;   // holds a count 0..NZ_CAPACITY

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    // one classified element on its way from front to back
    typedef struct packed {
        logic             nonzero;
        logic             mat_end;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } t_cmd;

    // one stored triplet
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_trip;

endpackage

// File: rtl/stct_front.sv
// ----------------------------------------------------------------------------
// stct_front
// config registers, position counters and element classification
// ----------------------------------------------------------------------------
module stct_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [stct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stct_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    input  logic [stct_pkg::VAL_W-1:0]     i_element_value,
    input  logic                           i_q_full,
    output logic                           o_push,
    output stct_pkg::t_cmd                 o_cmd
);
    import stct_pkg::*;

    logic [DIM_W-1:0] r_rows_cfg;
    logic [DIM_W-1:0] r_cols_cfg;
    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_col;

    logic [DIM_W-1:0] rows_c;
    logic [DIM_W-1:0] cols_c;
    logic [DIM_W-1:0] col_nx;
    logic [DIM_W-1:0] row_nx;
    logic             wrap_col;
    logic             mat_end;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign o_cfg_ready = 1'b1;

    assign rows_c   = clamp_dim(r_rows_cfg);
    assign cols_c   = clamp_dim(r_cols_cfg);
    assign col_nx   = {1'b0, r_col} + DIM_W'(1);
    assign row_nx   = {1'b0, r_row} + DIM_W'(1);
    assign wrap_col = (col_nx >= cols_c);
    assign mat_end  = wrap_col && (row_nx >= rows_c);

    assign o_push = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.nonzero = (i_element_value != '0);
        o_cmd.mat_end = mat_end;
        o_cmd.row     = r_row;
        o_cmd.col     = r_col;
        o_cmd.value   = i_element_value;
        o_cmd.rows    = rows_c;
        o_cmd.cols    = cols_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= DIM_W'(MAX_DIM);
            r_cols_cfg <= DIM_W'(MAX_DIM);
            r_row      <= '0;
            r_col      <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ROWS: r_rows_cfg <= i_cfg_data;
                    CFG_COLS: r_cols_cfg <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (o_push) begin
                if (wrap_col) begin
                    r_col <= '0;
                    r_row <= mat_end ? '0 : row_nx[POS_W-1:0];
                end else begin
                    r_col <= col_nx[POS_W-1:0];
                end
            end
        end
    end

endmodule

// File: rtl/stct_queue.sv
// ----------------------------------------------------------------------------
// stct_queue
// short fifo of classified elements between front and back
// ----------------------------------------------------------------------------
module stct_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  stct_pkg::t_cmd i_data,
    output logic           o_full,
    output logic           o_valid,
    output stct_pkg::t_cmd o_data,
    input  logic           i_pop
);
    import stct_pkg::*;

    t_cmd               r_buf [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/stct_back.sv
// ----------------------------------------------------------------------------
// stct_back
// triplet store and emit sequencer with output register
// ----------------------------------------------------------------------------
module stct_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  stct_pkg::t_cmd             i_cmd,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_list_id,
    output logic                       o_is_header,
    output logic [stct_pkg::DIM_W-1:0] o_row_out,
    output logic [stct_pkg::DIM_W-1:0] o_col_out,
    output logic [stct_pkg::VAL_W-1:0] o_value_out,
    output logic                       o_overflow,
    output logic                       o_last
);
    import stct_pkg::*;

    typedef enum logic [2:0] {
        S_RUN, S_HDR0, S_SP_RD, S_SP_OUT, S_HDR1, S_TR_RD, S_TR_CHK
    } t_state;

    t_trip            r_mem [NZ_CAPACITY];
    t_trip            r_rd;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic [DIM_W-1:0] r_rows;
    logic [DIM_W-1:0] r_cols;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_sent;
    logic [POS_W-1:0] r_tcol;

    logic             r_out_valid;
    logic             r_list;
    logic             r_hdr;
    logic [DIM_W-1:0] r_row_o;
    logic [DIM_W-1:0] r_col_o;
    logic [VAL_W-1:0] r_val_o;
    logic             r_ovf_o;
    logic             r_last_o;

    logic             slot_free;
    logic             store_wr;
    logic [CNT_W-1:0] count_m1;
    logic             idx_end;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign o_pop     = (r_state == S_RUN) && i_q_valid;
    assign store_wr  = o_pop && i_cmd.nonzero && (r_count < CNT_W'(NZ_CAPACITY));
    assign count_m1  = r_count - CNT_W'(1);
    assign idx_end   = (r_idx == count_m1);

    assign o_out_valid = r_out_valid;
    assign o_list_id   = r_list;
    assign o_is_header = r_hdr;
    assign o_row_out   = r_row_o;
    assign o_col_out   = r_col_o;
    assign o_value_out = r_val_o;
    assign o_overflow  = r_ovf_o;
    assign o_last      = r_last_o;

    // triplet store, registered read
    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            r_mem[r_count] <= '{row: i_cmd.row, col: i_cmd.col, value: i_cmd.value};
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_sent      <= '0;
            r_tcol      <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_RUN: begin
                    if (o_pop) begin
                        if (store_wr) begin
                            r_count <= r_count + CNT_W'(1);
                        end else if (i_cmd.nonzero) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_cmd.mat_end) begin
                            r_rows  <= i_cmd.rows;
                            r_cols  <= i_cmd.cols;
                            r_state <= S_HDR0;
                        end
                    end
                end
                S_HDR0: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_list      <= 1'b0;
                        r_hdr       <= 1'b1;
                        r_row_o     <= r_rows;
                        r_col_o     <= r_cols;
                        r_val_o     <= VAL_W'(r_count);
                        r_ovf_o     <= r_ovf;
                        r_last_o    <= 1'b0;
                        r_idx       <= '0;
                        r_state     <= (r_count == '0) ? S_HDR1 : S_SP_RD;
                    end
                end
                S_SP_RD: begin
                    r_state <= S_SP_OUT;
                end
                S_SP_OUT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_list      <= 1'b0;
                        r_hdr       <= 1'b0;
                        r_row_o     <= {1'b0, r_rd.row};
                        r_col_o     <= {1'b0, r_rd.col};
                        r_val_o     <= r_rd.value;
                        r_ovf_o     <= r_ovf;
                        r_last_o    <= 1'b0;
                        if (idx_end) begin
                            r_state <= S_HDR1;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_SP_RD;
                        end
                    end
                end
                S_HDR1: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_list      <= 1'b1;
                        r_hdr       <= 1'b1;
                        r_row_o     <= r_cols;
                        r_col_o     <= r_rows;
                        r_val_o     <= VAL_W'(r_count);
                        r_ovf_o     <= r_ovf;
                        r_last_o    <= (r_count == '0);
                        if (r_count == '0) begin
                            r_ovf   <= 1'b0;
                            r_state <= S_RUN;
                        end else begin
                            r_idx   <= '0;
                            r_sent  <= '0;
                            r_tcol  <= '0;
                            r_state <= S_TR_RD;
                        end
                    end
                end
                S_TR_RD: begin
                    r_state <= S_TR_CHK;
                end
                S_TR_CHK: begin
                    if (r_rd.col != r_tcol || slot_free) begin
                        if (r_rd.col == r_tcol) begin
                            r_out_valid <= 1'b1;
                            r_list      <= 1'b1;
                            r_hdr       <= 1'b0;
                            r_row_o     <= {1'b0, r_rd.col};
                            r_col_o     <= {1'b0, r_rd.row};
                            r_val_o     <= r_rd.value;
                            r_ovf_o     <= r_ovf;
                            r_last_o    <= (r_sent == count_m1);
                            r_sent      <= r_sent + CNT_W'(1);
                        end
                        if (r_rd.col == r_tcol && r_sent == count_m1) begin
                            // every stored triplet sent: ready for next matrix
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_RUN;
                        end else begin
                            if (idx_end) begin
                                r_idx  <= '0;
                                r_tcol <= r_tcol + POS_W'(1);
                            end else begin
                                r_idx <= r_idx + CNT_W'(1);
                            end
                            r_state <= S_TR_RD;
                        end
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

endmodule

// File: rtl/sparse_triplet_compress_transpose.sv
// ----------------------------------------------------------------------------
// sparse_triplet_compress_transpose
// dense matrix in, sparse triplet list and transposed triplet list out
// ----------------------------------------------------------------------------
// usage:
//   config port (i_cfg_valid/o_cfg_ready, index, data) sets the row count
//   (index 0) and column count (index 1); reset value 16 each, 0 acts as 1,
//   values above 16 act as 16. write only while the block is idle.
//   input channel (i_in_valid/o_in_stall) takes one element per cycle
//   while not stalled, in row-major order. nonzeros are stored, up to 31;
//   extra ones are dropped and flagged on every result of that matrix.
//   after the last element the output channel (o_out_valid/i_out_stall)
//   carries the sparse header, the stored triplets, the transposed header
//   and the transposed triplets, with o_last on the final item.
//   each sparse triplet and each visited (column, store entry) pair in the
//   transposed walk takes a read state and an output or check state, set by
//   the registered store read port; the walk visits at most 16 * count pairs.
//   a 4-deep queue lets the next matrix start loading during the emit; the
//   input stalls once it fills. a stalled output item holds its payload.
//   reset clears counters and queue, resets config; store needs no clear.
// ----------------------------------------------------------------------------
module sparse_triplet_compress_transpose (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [stct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stct_pkg::DIM_W-1:0]     i_cfg_data,
    // element input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [31:0]             i_element_value,
    // result output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_list_id,
    output logic                           o_is_header,
    output logic [4:0]                     o_row_out,
    output logic [4:0]                     o_col_out,
    output logic signed [31:0]             o_value_out,
    output logic                           o_overflow,
    output logic                           o_last
);
    import stct_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    logic [VAL_W-1:0] value_bits;

    // front stalls the input only when the queue is full
    assign o_in_stall = q_full;

    // front: position tracking and classification of each element
    stct_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_element_value (VAL_W'(i_element_value)),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    // decoupling queue
    stct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_cmd),
        .i_pop   (pop)
    );

    // back: store writes and the two-list emit
    stct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_list_id   (o_list_id),
        .o_is_header (o_is_header),
        .o_row_out   (o_row_out),
        .o_col_out   (o_col_out),
        .o_value_out (value_bits),
        .o_overflow  (o_overflow),
        .o_last      (o_last)
    );

    assign o_value_out = signed'(value_bits);

endmodule
